>>> hdl/jsu_pkg.sv
package jsu_pkg;

    // most results one input byte can cause: lone high surrogate plus a new code point
    localparam int MaxRes = 6;
    localparam int CntW   = $clog2(MaxRes + 1);

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_ESC = 2'd0,
        ERR_HEX = 2'd1,
        ERR_EOB = 2'd2
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_err        err;
    } t_res;

    // results of one input byte, in output order
    typedef struct packed {
        logic [CntW-1:0]    cnt;
        t_res [MaxRes-1:0]  ent;
    } t_res_list;

endpackage

>>> hdl/jsu_decode.sv
module jsu_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [7:0]         i_byte,
    input  logic               i_eob,
    output jsu_pkg::t_res_list o_list
);
    import jsu_pkg::*;

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChU = 8'h75;

    typedef enum logic [5:0] {
        M_NORMAL  = 6'b000001,
        M_ESC     = 6'b000010,
        M_HEX1    = 6'b000100,
        M_HIGH    = 6'b001000,
        M_HIGH_BS = 6'b010000,
        M_HEX2    = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][7:0]  b;
    } t_utf8;

    typedef struct packed {
        logic       ok;
        logic [7:0] v;
    } t_byte_opt;

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 u;
        u.b = '0;
        if (cp < 21'h80) begin
            u.n = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.n = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.n = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.n = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    function automatic t_byte_opt hex_val(input logic [7:0] c);
        t_byte_opt h;
        h.ok = 1'b1;
        h.v  = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.v = c - 8'h57;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_byte_opt simple_esc(input logic [7:0] c);
        t_byte_opt s;
        s.ok = 1'b1;
        case (c)
            8'h22, 8'h5C, 8'h2F: s.v = c;
            8'h6E: s.v = 8'h0A;
            8'h72: s.v = 8'h0D;
            8'h74: s.v = 8'h09;
            8'h62: s.v = 8'h08;
            8'h66: s.v = 8'h0C;
            default: begin
                s.ok = 1'b0;
                s.v  = 8'h00;
            end
        endcase
        return s;
    endfunction

    function automatic logic is_high(input logic [15:0] c);
        return c >= 16'hD800 && c <= 16'hDBFF;
    endfunction

    function automatic logic is_low(input logic [15:0] c);
        return c >= 16'hDC00 && c <= 16'hDFFF;
    endfunction

    t_mode       r_mode, n_mode;
    logic [15:0] r_pend, n_pend;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_dcnt, n_dcnt;

    logic        en_a, en_b, en_s, ended, err_v;
    t_err        err_c;
    logic [20:0] cp_a, cp_b;
    logic [7:0]  s_byte;
    t_utf8       u_a, u_b;
    t_byte_opt   hx, se;
    logic [15:0] code;
    logic [3:0]  n_a, n_b, n_s, total;

    always_comb begin
        n_mode = M_NORMAL;
        n_pend = r_pend;
        n_acc  = r_acc;
        n_dcnt = r_dcnt;
        en_a   = 1'b0;
        en_b   = 1'b0;
        en_s   = 1'b0;
        cp_a   = '0;
        cp_b   = '0;
        s_byte = i_byte;
        ended  = 1'b0;
        err_v  = 1'b0;
        err_c  = ERR_ESC;
        hx     = hex_val(i_byte);
        se     = simple_esc(i_byte);
        code   = {r_acc[11:0], hx.v[3:0]};

        case (r_mode)
            M_ESC: begin
                if (i_byte == ChU) begin
                    n_mode = M_HEX1;
                    n_acc  = '0;
                    n_dcnt = '0;
                end else if (se.ok) begin
                    en_s   = 1'b1;
                    s_byte = se.v;
                end else begin
                    err_v = 1'b1;
                end
            end
            M_HEX1, M_HEX2: begin
                if (!hx.ok) begin
                    err_v = 1'b1;
                    err_c = ERR_HEX;
                end else if (r_dcnt != 2'd3) begin
                    n_acc  = code;
                    n_dcnt = r_dcnt + 2'd1;
                    n_mode = r_mode;
                end else begin
                    n_acc  = '0;
                    n_dcnt = '0;
                    if (r_mode == M_HEX2 && is_high(r_pend) && is_low(code)) begin
                        // surrogate pair: both low ten-bit parts form the offset
                        en_a   = 1'b1;
                        cp_a   = 21'h10000 + {1'b0, r_pend[9:0], code[9:0]};
                        n_pend = '0;
                    end else begin
                        if (r_mode == M_HEX2) begin
                            en_a   = 1'b1;
                            cp_a   = {5'd0, r_pend};
                            n_pend = '0;
                        end
                        if (is_high(code)) begin
                            n_pend = code;
                            n_mode = M_HIGH;
                        end else begin
                            en_b = 1'b1;
                            cp_b = {5'd0, code};
                        end
                    end
                end
            end
            M_HIGH: begin
                if (i_byte == ChBslash) begin
                    n_mode = M_HIGH_BS;
                end else begin
                    en_a   = 1'b1;
                    cp_a   = {5'd0, r_pend};
                    n_pend = '0;
                    if (i_byte == ChQuote) begin
                        ended = 1'b1;
                    end else begin
                        en_s = 1'b1;
                    end
                end
            end
            M_HIGH_BS: begin
                if (i_byte == ChU) begin
                    n_mode = M_HEX2;
                    n_acc  = '0;
                    n_dcnt = '0;
                end else begin
                    en_a   = 1'b1;
                    cp_a   = {5'd0, r_pend};
                    n_pend = '0;
                    if (se.ok) begin
                        en_s   = 1'b1;
                        s_byte = se.v;
                    end else begin
                        err_v = 1'b1;
                    end
                end
            end
            default: begin
                if (i_byte == ChQuote) begin
                    ended = 1'b1;
                end else if (i_byte == ChBslash) begin
                    n_mode = M_ESC;
                end else begin
                    en_s = 1'b1;
                end
            end
        endcase

        if (!err_v && !ended && i_eob) begin
            err_v = 1'b1;
            err_c = ERR_EOB;
        end

        if (err_v || ended) begin
            n_mode = M_NORMAL;
            n_pend = '0;
            n_acc  = '0;
            n_dcnt = '0;
        end
    end

    // byte groups in order: first code point, second, single byte, end mark; or error
    always_comb begin
        logic [3:0] kk;
        logic [3:0] ofs;
        u_a   = utf8_enc(cp_a);
        u_b   = utf8_enc(cp_b);
        n_a   = en_a ? {1'b0, u_a.n} : 4'd0;
        n_b   = en_b ? {1'b0, u_b.n} : 4'd0;
        n_s   = en_s ? 4'd1 : 4'd0;
        total = n_a + n_b + n_s + (ended ? 4'd1 : 4'd0);
        o_list.cnt = total[CntW-1:0];
        for (int k = 0; k < MaxRes; k++) begin
            kk = 4'(k);
            ofs = kk - n_a;
            if (kk < n_a) begin
                o_list.ent[k] = '{kind: KIND_DATA, data: u_a.b[kk[1:0]], err: ERR_ESC};
            end else if (kk < n_a + n_b) begin
                o_list.ent[k] = '{kind: KIND_DATA, data: u_b.b[ofs[1:0]], err: ERR_ESC};
            end else if (kk < n_a + n_b + n_s) begin
                o_list.ent[k] = '{kind: KIND_DATA, data: s_byte, err: ERR_ESC};
            end else begin
                o_list.ent[k] = '{kind: KIND_END, data: 8'h00, err: ERR_ESC};
            end
        end
        if (err_v) begin
            o_list.cnt    = CntW'(1);
            o_list.ent[0] = '{kind: KIND_ERR, data: 8'h00, err: err_c};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_pend <= '0;
            r_acc  <= '0;
            r_dcnt <= '0;
        end else if (i_load) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_dcnt <= n_dcnt;
        end
    end

endmodule

>>> hdl/jsu_outbuf.sv
module jsu_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  jsu_pkg::t_res_list i_list,
    input  logic               i_tready,
    output logic               o_free,
    output logic               o_tvalid,
    output logic               o_tlast,
    output jsu_pkg::t_res      o_res
);
    import jsu_pkg::*;

    logic [CntW-1:0]   r_cnt;
    t_res [MaxRes-1:0] r_ent;
    logic              pop;

    assign pop      = (r_cnt != '0) && i_tready;
    assign o_free   = (r_cnt == '0) || ((r_cnt == CntW'(1)) && i_tready);
    assign o_tvalid = r_cnt != '0;
    assign o_tlast  = r_cnt == CntW'(1);
    assign o_res    = r_ent[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_list.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    // results leave from slot zero, the rest move down one place per transaction
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_list.ent;
        end else if (pop) begin
            for (int k = 0; k < MaxRes - 1; k++) begin
                r_ent[k] <= r_ent[k+1];
            end
        end
    end

endmodule

>>> hdl/json_string_unescape_utf8.sv
// json string body unescaper with utf-8 output
//
// slave stream: one raw byte of a string body (after the opening quote) per
// transaction; s_axis_tlast marks the last byte available in the buffer
// master stream: one result per transaction; m_axis_tuser gives its kind
// (data byte, string end, error), m_axis_tdata the decoded byte and the
// error code, m_axis_tlast the final result caused by one input byte
//
// a byte's results: the accepting edge fills the input register, and the
// results move into the result buffer, where the first is valid, once the
// buffer can take them
// throughput: one byte per cycle while each byte gives at most one result
// and the receiver takes each; a byte with more (up to six) holds the input
// side until the result buffer, drained one result per transaction, sends its last
//
// reset clears the input register, the result buffer and the decoder, which
// starts in plain text mode; after a string end or an error it returns there
// when the receiver stalls, the pending result holds and one more byte waits
// in the input register before s_axis_tready drops
module json_string_unescape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last result of the input byte
);
    import jsu_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_eob;
    logic       buf_free;
    logic       load;
    t_res_list  res_list;
    t_res       out_res;

    // the input register hands its byte to the decoder once the buffer can take the results
    assign load          = r_in_vld && buf_free;
    assign s_axis_tready = !r_in_vld || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eob  <= s_axis_tlast;
        end
    end

    // decoder state and result layout for the held byte
    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_byte  (r_in_byte),
        .i_eob   (r_in_eob),
        .o_list  (res_list)
    );

    // result buffer, drained one result per transaction
    jsu_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_list   (res_list),
        .i_tready (m_axis_tready),
        .o_free   (buf_free),
        .o_tvalid (m_axis_tvalid),
        .o_tlast  (m_axis_tlast),
        .o_res    (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.err, out_res.data};
    assign m_axis_tuser = out_res.kind;

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    // characters that form a one-byte escape after a backslash
    localparam logic [7:0] ESC_CHARS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h6E,
                                             8'h72, 8'h74, 8'h62, 8'h66};

    localparam int RAND_PER_PHASE = 78;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [3:0] {
        MD_TEXT    = 4'd0,
        MD_ESC     = 4'd1,
        MD_HEX1    = 4'd2,
        MD_HIGH    = 4'd3,
        MD_HIGH_BS = 4'd4,
        MD_HEX2    = 4'd5
    } t_dec_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_err       err;
        logic       last;
    } t_unesc_res;

    // directed row: byte, end of buffer, and optionally its single result
    typedef struct {
        logic [7:0] b;
        logic       eob;
        bit         typed;
        t_kind      kind;
        logic [7:0] data;
        t_err       err;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic        s_axis_tlast;   // end_of_buffer
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] out_byte, [9:8] error_code, rest zero
    logic [1:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;   // last result of the input byte

    // decoder copy
    t_dec_mode   dec_mode;
    logic [15:0] held_high;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;

    t_unesc_res  byte_res[$];    // results of the byte just decoded
    t_unesc_res  utf8_exp_q[$];  // results still owed by the block

    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    logic        sink_hold     = 1'b0;
    int          bytes_sent    = 0;
    int          mismatches    = 0;

    t_dir_row dir_tab [27] = '{
        // byte extremes pass through
        '{8'h00,  1'b0, 1'b1, KIND_DATA, 8'h00, ERR_ESC},
        '{8'hFF,  1'b0, 1'b1, KIND_DATA, 8'hFF, ERR_ESC},
        // newline escape
        '{CH_BSL, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h6E,  1'b0, 1'b1, KIND_DATA, 8'h0A, ERR_ESC},
        // bad escape character
        '{CH_BSL, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h71,  1'b0, 1'b1, KIND_ERR,  8'h00, ERR_ESC},
        // highest surrogate pair \uDBFF\udfff
        '{CH_BSL, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{CH_U,   1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h44,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h42,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h46,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h46,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{CH_BSL, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{CH_U,   1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h64,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h66,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h66,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h66,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        // lowest high surrogate left alone, then the closing quote
        '{CH_BSL, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{CH_U,   1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h64,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h38,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h30,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{8'h30,  1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_ESC},
        // buffer runs out inside a string, then an empty string
        '{8'h78,  1'b1, 1'b1, KIND_ERR,  8'h00, ERR_EOB},
        '{CH_QUOTE, 1'b0, 1'b1, KIND_END, 8'h00, ERR_ESC}
    };

    json_string_unescape_utf8 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #800_000;
        $display("json_string_unescape_utf8 regression: fail");
        $finish;
    end

    // ---------------- decoder prediction ----------------

    function automatic void emit(input t_kind k, input logic [7:0] d, input t_err e);
        t_unesc_res r;
        r = '{kind: k, data: d, err: e, last: 1'b0};
        byte_res = {byte_res, r};
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(KIND_DATA, cp[7:0], ERR_ESC);
        end else if (cp < 21'h800) begin
            emit(KIND_DATA, 8'hC0 | {3'b0, cp[10:6]}, ERR_ESC);
            emit(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_ESC);
        end else if (cp < 21'h10000) begin
            emit(KIND_DATA, 8'hE0 | {4'b0, cp[15:12]}, ERR_ESC);
            emit(KIND_DATA, 8'h80 | {2'b0, cp[11:6]}, ERR_ESC);
            emit(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_ESC);
        end else begin
            emit(KIND_DATA, 8'hF0 | {5'b0, cp[20:18]}, ERR_ESC);
            emit(KIND_DATA, 8'h80 | {2'b0, cp[17:12]}, ERR_ESC);
            emit(KIND_DATA, 8'h80 | {2'b0, cp[11:6]}, ERR_ESC);
            emit(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_ESC);
        end
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    // one-byte escape; returns 0 if c is not one
    function automatic bit simple_esc(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            8'h22, 8'h5C, 8'h2F: v = c;
            8'h6E: v = 8'h0A;
            8'h72: v = 8'h0D;
            8'h74: v = 8'h09;
            8'h62: v = 8'h08;
            8'h66: v = 8'h0C;
            default: return 1'b0;
        endcase
        emit(KIND_DATA, v, ERR_ESC);
        return 1'b1;
    endfunction

    // byte in plain text; returns 1 on the closing quote
    function automatic bit plain_text(input logic [7:0] c);
        if (c == CH_QUOTE) return 1'b1;
        if (c == CH_BSL) begin
            dec_mode = MD_ESC;
        end else begin
            emit(KIND_DATA, c, ERR_ESC);
        end
        return 1'b0;
    endfunction

    function automatic void reset_decoder();
        dec_mode  = MD_TEXT;
        held_high = '0;
        hex_acc   = '0;
        hex_cnt   = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic eob);
        t_dec_mode   md;
        int          hv;
        bit          ended;
        bit          failed;
        t_err        code;
        logic [15:0] cu;
        md     = dec_mode;
        ended  = 1'b0;
        failed = 1'b0;
        code   = ERR_ESC;
        byte_res.delete();
        dec_mode = MD_TEXT;
        case (md)
            MD_ESC: begin
                if (c == CH_U) begin
                    dec_mode = MD_HEX1;
                    hex_acc  = '0;
                    hex_cnt  = '0;
                end else if (!simple_esc(c)) begin
                    failed = 1'b1;
                end
            end
            MD_HEX1, MD_HEX2: begin
                hv = hex_val(c);
                if (hv < 0) begin
                    failed = 1'b1;
                    code   = ERR_HEX;
                end else begin
                    hex_acc = {hex_acc[11:0], hv[3:0]};
                    if (hex_cnt != 2'd3) begin
                        hex_cnt  = hex_cnt + 2'd1;
                        dec_mode = md;
                    end else begin
                        hex_cnt = '0;
                        cu      = hex_acc;
                        hex_acc = '0;
                        if (md == MD_HEX2 && cu >= 16'hDC00 && cu <= 16'hDFFF) begin
                            // pair: both halves carry ten bits of the offset
                            emit_utf8(21'h10000 + {1'b0, held_high[9:0], cu[9:0]});
                            held_high = '0;
                        end else begin
                            if (md == MD_HEX2) begin
                                emit_utf8({5'b0, held_high});
                                held_high = '0;
                            end
                            if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
                                held_high = cu;
                                dec_mode  = MD_HIGH;
                            end else begin
                                emit_utf8({5'b0, cu});
                            end
                        end
                    end
                end
            end
            MD_HIGH: begin
                if (c == CH_BSL) begin
                    dec_mode = MD_HIGH_BS;
                end else begin
                    emit_utf8({5'b0, held_high});
                    held_high = '0;
                    ended     = plain_text(c);
                end
            end
            MD_HIGH_BS: begin
                if (c == CH_U) begin
                    dec_mode = MD_HEX2;
                    hex_acc  = '0;
                    hex_cnt  = '0;
                end else begin
                    emit_utf8({5'b0, held_high});
                    held_high = '0;
                    if (!simple_esc(c)) failed = 1'b1;
                end
            end
            default: begin
                ended = plain_text(c);
            end
        endcase
        if (!failed && !ended && eob) begin
            failed = 1'b1;
            code   = ERR_EOB;
        end
        if (failed || ended) reset_decoder();
        if (failed) begin
            // an error drops whatever data the byte produced
            byte_res.delete();
            emit(KIND_ERR, 8'h00, code);
        end else if (ended) begin
            emit(KIND_END, 8'h00, ERR_ESC);
        end
        if (byte_res.size() > 0) byte_res[byte_res.size()-1].last = 1'b1;
    endfunction

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_unesc_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (utf8_exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result tuser=%0d tdata=%h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                e = utf8_exp_q.pop_front();
                if (m_axis_tuser !== e.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d", m_axis_tuser, e.kind));
                if (m_axis_tdata !== {6'b0, e.err, e.data})
                    report_mismatch($sformatf("tdata %h, wanted %h",
                                              m_axis_tdata, {6'b0, e.err, e.data}));
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("tlast %b, wanted %b", m_axis_tlast, e.last));
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering bytes
    task automatic hold_sink(input int cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(negedge i_clk);
        sink_hold <= 1'b0;
    endtask

    // ---------------- sender ----------------

    // called just after a falling edge, returns just after one
    task automatic send_byte(input logic [7:0] b, input logic eob,
                             input bit typed = 1'b0, input t_unesc_res typed_res = '0);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(b, eob);
        if (typed) begin
            typed_res.last = 1'b1;
            utf8_exp_q = {utf8_exp_q, typed_res};
        end else begin
            utf8_exp_q = {utf8_exp_q, byte_res};
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // rare end-of-buffer flag on well-formed bytes
    task automatic send_tok(input logic [7:0] b);
        send_byte(b, $urandom_range(99) == 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'b0, v};
        return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'b0, v} - 8'd10;
    endfunction

    task automatic send_u_escape(input logic [15:0] cu);
        send_tok(CH_BSL);
        send_tok(CH_U);
        for (int i = 3; i >= 0; i--) send_tok(hex_char(cu[i*4 +: 4]));
    endtask

    function automatic logic [15:0] rand_code();
        case ($urandom_range(4))
            0: return 16'($urandom_range(16'h7F));
            1: return 16'($urandom_range(16'h7FF, 16'h80));
            2: return 16'($urandom_range(16'hD7FF, 16'h800));
            3: return 16'($urandom_range(16'hFFFF, 16'hE000));
            default: return 16'($urandom_range(16'hDFFF, 16'hDC00));
        endcase
    endfunction

    function automatic bit is_esc_char(input logic [7:0] c);
        if (c == CH_U) return 1'b1;
        foreach (ESC_CHARS[i]) if (c == ESC_CHARS[i]) return 1'b1;
        return 1'b0;
    endfunction

    task automatic send_random_token();
        int         pick;
        logic [7:0] c;
        logic [15:0] hi;
        pick = $urandom_range(99);
        hi   = 16'($urandom_range(16'hDBFF, 16'hD800));
        if (pick < 30) begin
            // plain byte
            c = 8'($urandom_range(255));
            if (c == CH_QUOTE || c == CH_BSL) c = c ^ 8'h01;
            send_tok(c);
        end else if (pick < 44) begin
            send_tok(CH_BSL);
            send_tok(ESC_CHARS[$urandom_range(7)]);
        end else if (pick < 62) begin
            send_u_escape(rand_code());
        end else if (pick < 76) begin
            // surrogate pair
            send_u_escape(hi);
            send_u_escape(16'($urandom_range(16'hDFFF, 16'hDC00)));
        end else if (pick < 81) begin
            // held high surrogate followed by a \u that is not a low one
            send_u_escape(hi);
            if ($urandom_range(1)) begin
                send_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
            end else begin
                c = 8'h0;
                send_u_escape(16'($urandom_range(16'hD7FF)));
            end
        end else if (pick < 85) begin
            // held high surrogate, then a one-byte or bad escape
            send_u_escape(hi);
            send_tok(CH_BSL);
            if ($urandom_range(1)) begin
                send_tok(ESC_CHARS[$urandom_range(7)]);
            end else begin
                do c = 8'($urandom_range(255)); while (is_esc_char(c));
                send_tok(c);
            end
        end else if (pick < 89) begin
            send_tok(CH_QUOTE);
        end else if (pick < 92) begin
            // bad escape
            send_tok(CH_BSL);
            do c = 8'($urandom_range(255)); while (is_esc_char(c));
            send_tok(c);
        end else if (pick < 95) begin
            // bad hex digit after up to three good ones
            send_tok(CH_BSL);
            send_tok(CH_U);
            repeat ($urandom_range(3)) send_tok(hex_char(4'($urandom_range(15))));
            do c = 8'($urandom_range(255)); while (hex_val(c) >= 0);
            send_tok(c);
        end else begin
            // noise
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) send_random_token();
    endtask

    // sender pause until every owed result has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (utf8_exp_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_unesc_res tr;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        reset_decoder();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct  = 17;
        sink_idle_pct = 51;
        foreach (dir_tab[i]) begin
            tr = '{kind: dir_tab[i].kind, data: dir_tab[i].data,
                   err: dir_tab[i].err, last: 1'b1};
            send_byte(dir_tab[i].b, dir_tab[i].eob, dir_tab[i].typed, tr);
        end
        wait_drained();

        run_random(30);
        fork
            hold_sink(200);
        join_none
        run_random(RAND_PER_PHASE - 30);

        src_idle_pct  = 51;
        sink_idle_pct = 17;
        run_random(RAND_PER_PHASE);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        fork
            hold_sink(150);
        join_none
        run_random(RAND_PER_PHASE);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("json_string_unescape_utf8 regression: pass");
        end else begin
            $display("json_string_unescape_utf8 regression: fail");
        end
        $finish;
    end

endmodule
